// ----- hw/rtl/fmqd_pkg.sv -----
// ----------------------------------------------------------------------------
// fmqd_pkg
// Shared types and constants of the FM quadrature discriminator.
// ----------------------------------------------------------------------------
`default_nettype none

package fmqd_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT  = 16;
   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_ENTRIES          = 24;

   localparam int GAIN_WIDTH  = 16;
   localparam int AUDIO_WIDTH = 24;
   localparam int ANGLE_WIDTH = 17;
   localparam int PROD_WIDTH  = ANGLE_WIDTH + GAIN_WIDTH + 1;
   localparam int Z_WIDTH     = 32;

   localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd328;

   // quarter turn, in units of pi with 30 fractional bits
   localparam logic signed [Z_WIDTH-1:0] Z_QUARTER = 32'sd536870912;
   localparam logic signed [Z_WIDTH-1:0] Z_ROUND   = 32'sd16384;

   // atan(2^-k) / pi, 30 fractional bits
   localparam logic signed [Z_WIDTH-1:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
      32'sd268435456, 32'sd158466703, 32'sd83729454, 32'sd42502378,
      32'sd21333666,  32'sd10677233,  32'sd5339919,  32'sd2670123,
      32'sd1335082,   32'sd667543,    32'sd333772,   32'sd166886,
      32'sd83443,     32'sd41722,     32'sd20861,    32'sd10430,
      32'sd5215,      32'sd2608,      32'sd1304,     32'sd652,
      32'sd326,       32'sd163,       32'sd81,       32'sd41
   };

   typedef struct packed {
      logic valid;
      logic zero;
   } fmqd_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fm_quadrature_discriminator.sv -----
// ----------------------------------------------------------------------------
// fm_quadrature_discriminator
// FM demodulator: angle of conj(previous) * current via a CORDIC cell chain.
// ----------------------------------------------------------------------------
// Usage
//   req_*: one complex sample per transaction, I in the low half of tdata.
//   rsp_*: one signed Q9.15 audio sample per input transaction, in order.
//   csr_*: gain (Q8.8) write, taken whenever csr_wen is high; write it only
//          while the stream is idle.
//   Throughput: one sample per clock, sustained while rsp_tready stays high.
//   Path: the mixer, the CORDIC cells (stage count capped at 24), the scaler
//         and the rsp register lie between the input transaction and rsp_tvalid.
//   Stall: the whole pipeline advances together. When rsp_tready is low a
//          skid register catches one more result, after which req_tready
//          drops until the held result is taken.
//   Reset: clears the previous sample to zero (the first output is 0), sets
//          gain to 1.28125 and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_quadrature_discriminator
   import fmqd_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEFAULT,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT,
   parameter int REQ_WIDTH     = 8 * ((2 * SAMPLE_WIDTH + 7) / 8)
)(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_WIDTH-1:0]   req_tdata,   // in_i, in_q
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [AUDIO_WIDTH-1:0]      rsp_tdata,   // audio
   input  wire logic                   csr_wen,
   input  wire logic [GAIN_WIDTH-1:0]  csr_wdata    // gain
);

   localparam int NSTG    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int X_WIDTH = 2 * SAMPLE_WIDTH + 3;

   logic                           en, accept;
   logic signed [SAMPLE_WIDTH-1:0] cur_i, cur_q;
   logic signed [SAMPLE_WIDTH-1:0] pri_i_ff, pri_q_ff;
   logic [GAIN_WIDTH-1:0]          gain_ff, gain_in;

   fmqd_ctl_type              c_ctl [0:NSTG];
   logic signed [X_WIDTH-1:0] c_x   [0:NSTG];
   logic signed [X_WIDTH-1:0] c_y   [0:NSTG];
   logic signed [Z_WIDTH-1:0] c_z   [0:NSTG];

   logic                          pipe_valid, emit, out_load;
   logic signed [AUDIO_WIDTH-1:0] pipe_audio;
   logic                          rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic [AUDIO_WIDTH-1:0]        rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;
   assign cur_i      = req_tdata[SAMPLE_WIDTH-1:0];
   assign cur_q      = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign gain_in    = csr_wen ? csr_wdata : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pri_i_ff <= '0;
         pri_q_ff <= '0;
         gain_ff  <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
         if (accept) begin
            pri_i_ff <= cur_i;
            pri_q_ff <= cur_q;
         end
      end
   end

   fmqd_mixer #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .X_WIDTH      (X_WIDTH)
   ) u_mixer (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (accept),
      .cur_i    (cur_i),
      .cur_q    (cur_q),
      .pri_i    (pri_i_ff),
      .pri_q    (pri_q_ff),
      .out_ctl  (c_ctl[0]),
      .out_x    (c_x[0]),
      .out_y    (c_y[0]),
      .out_z    (c_z[0])
   );

   for (genvar k = 0; k < NSTG; k++) begin : g_cell
      fmqd_cordic_cell #(
         .X_WIDTH (X_WIDTH),
         .STAGE   (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .in_ctl  (c_ctl[k]),
         .in_x    (c_x[k]),
         .in_y    (c_y[k]),
         .in_z    (c_z[k]),
         .out_ctl (c_ctl[k+1]),
         .out_x   (c_x[k+1]),
         .out_y   (c_y[k+1]),
         .out_z   (c_z[k+1])
      );
   end

   fmqd_scaler u_scaler (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (c_ctl[NSTG]),
      .in_z      (c_z[NSTG]),
      .gain      (gain_ff),
      .out_valid (pipe_valid),
      .out_audio (pipe_audio)
   );

   assign emit     = en && pipe_valid;
   assign out_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (out_load) begin
         rsp_valid_in  = skid_valid_ff || emit;
         rsp_data_in   = skid_valid_ff ? skid_data_ff : pipe_audio;
         skid_valid_in = 1'b0;
         skid_data_in  = skid_data_ff;
      end else begin
         rsp_valid_in  = rsp_valid_ff;
         rsp_data_in   = rsp_data_ff;
         skid_valid_in = skid_valid_ff || emit;
         skid_data_in  = emit ? pipe_audio : skid_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fmqd_mixer.sv -----
// ----------------------------------------------------------------------------
// fmqd_mixer
// Forms conj(prior) * current over two stages, then applies the quarter-turn
// pre-rotation that brings the vector into the right half-plane.
// ----------------------------------------------------------------------------
`default_nettype none

module fmqd_mixer
   import fmqd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int X_WIDTH      = 2 * SAMPLE_WIDTH + 3
)(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           en,
   input  wire logic                           in_valid,
   input  wire logic signed [SAMPLE_WIDTH-1:0] cur_i,
   input  wire logic signed [SAMPLE_WIDTH-1:0] cur_q,
   input  wire logic signed [SAMPLE_WIDTH-1:0] pri_i,
   input  wire logic signed [SAMPLE_WIDTH-1:0] pri_q,
   output fmqd_ctl_type                        out_ctl,
   output logic signed [X_WIDTH-1:0]           out_x,
   output logic signed [X_WIDTH-1:0]           out_y,
   output logic signed [Z_WIDTH-1:0]           out_z
);

   localparam int PW = 2 * SAMPLE_WIDTH;

   logic                 v1_ff, v1_in, v2_ff, v2_in;
   logic signed [PW-1:0] pp_ii_ff, pp_qq_ff, pp_iq_ff, pp_qi_ff;
   logic signed [PW-1:0] pp_ii_in, pp_qq_in, pp_iq_in, pp_qi_in;
   logic signed [PW:0]   re_ff, im_ff, re_in, im_in;
   logic signed [X_WIDTH-1:0] re_x, im_x;
   fmqd_ctl_type              ctl_ff, ctl_in;
   logic signed [X_WIDTH-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [Z_WIDTH-1:0] z_ff, z_in;

   assign v1_in    = in_valid;
   assign pp_ii_in = pri_i * cur_i;
   assign pp_qq_in = pri_q * cur_q;
   assign pp_iq_in = pri_i * cur_q;
   assign pp_qi_in = pri_q * cur_i;

   assign v2_in = v1_ff;
   assign re_in = {pp_ii_ff[PW-1], pp_ii_ff} + {pp_qq_ff[PW-1], pp_qq_ff};
   assign im_in = {pp_iq_ff[PW-1], pp_iq_ff} - {pp_qi_ff[PW-1], pp_qi_ff};

   assign re_x = {{(X_WIDTH-PW-1){re_ff[PW]}}, re_ff};
   assign im_x = {{(X_WIDTH-PW-1){im_ff[PW]}}, im_ff};

   always_comb begin
      ctl_in.valid = v2_ff;
      ctl_in.zero  = (re_ff == '0) && (im_ff == '0);
      x_in = re_x;
      y_in = im_x;
      z_in = '0;
      if (re_ff[PW]) begin
         if (!im_ff[PW]) begin
            x_in = im_x;
            y_in = -re_x;
            z_in = Z_QUARTER;
         end else begin
            x_in = -im_x;
            y_in = re_x;
            z_in = -Z_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ii_ff <= pp_ii_in;
         pp_qq_ff <= pp_qq_in;
         pp_iq_ff <= pp_iq_in;
         pp_qi_ff <= pp_qi_in;
         re_ff    <= re_in;
         im_ff    <= im_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fmqd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// fmqd_cordic_cell
// One vectoring CORDIC micro-rotation with its own registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module fmqd_cordic_cell
   import fmqd_pkg::*;
#(
   parameter int X_WIDTH = 2 * SAMPLE_WIDTH_DEFAULT + 3,
   parameter int STAGE   = 0
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire fmqd_ctl_type              in_ctl,
   input  wire logic signed [X_WIDTH-1:0] in_x,
   input  wire logic signed [X_WIDTH-1:0] in_y,
   input  wire logic signed [Z_WIDTH-1:0] in_z,
   output fmqd_ctl_type                   out_ctl,
   output logic signed [X_WIDTH-1:0]      out_x,
   output logic signed [X_WIDTH-1:0]      out_y,
   output logic signed [Z_WIDTH-1:0]      out_z
);

   logic                      rot_down;
   logic signed [X_WIDTH-1:0] xs, ys, x_ff, y_ff, x_in, y_in;
   logic signed [Z_WIDTH-1:0] z_ff, z_in;
   fmqd_ctl_type              ctl_ff;

   assign xs       = in_x >>> STAGE;
   assign ys       = in_y >>> STAGE;
   assign rot_down = !in_y[X_WIDTH-1] && (in_y != '0);

   always_comb begin
      if (rot_down) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN_TABLE[STAGE];
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fmqd_scaler.sv -----
// ----------------------------------------------------------------------------
// fmqd_scaler
// Rounds the CORDIC angle to Q2.15, applies the Q8.8 gain and saturates the
// audio sample to 24 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fmqd_scaler
   import fmqd_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire fmqd_ctl_type                  in_ctl,
   input  wire logic signed [Z_WIDTH-1:0]     in_z,
   input  wire logic        [GAIN_WIDTH-1:0]  gain,
   output logic                               out_valid,
   output logic signed [AUDIO_WIDTH-1:0]      out_audio
);

   localparam int SW = PROD_WIDTH - 8;
   localparam logic signed [SW-1:0] SAT_MAX = SW'(2 ** (AUDIO_WIDTH - 1) - 1);
   localparam logic signed [SW-1:0] SAT_MIN = -SW'(2 ** (AUDIO_WIDTH - 1));

   logic signed [Z_WIDTH-1:0]     z_rnd, z_sh;
   logic                          va_ff, va_in, vp_ff, vp_in;
   logic signed [ANGLE_WIDTH-1:0] ang_ff, ang_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in, prod_rnd;
   logic signed [SW-1:0]          scaled;

   assign z_rnd = in_z + Z_ROUND;
   assign z_sh  = z_rnd >>> 15;
   assign va_in = in_ctl.valid;

   always_comb begin
      if (in_ctl.zero) begin
         ang_in = '0;
      end else if (!z_sh[ANGLE_WIDTH-1] && z_sh[ANGLE_WIDTH-2]) begin
         // plus pi wraps to minus pi
         ang_in = {1'b1, z_sh[ANGLE_WIDTH-2:0]};
      end else begin
         ang_in = z_sh[ANGLE_WIDTH-1:0];
      end
   end

   assign vp_in   = va_ff;
   assign prod_in = ang_ff * $signed({1'b0, gain});

   assign prod_rnd = prod_ff + PROD_WIDTH'(128);
   assign scaled   = prod_rnd[PROD_WIDTH-1:8];

   always_comb begin
      if (scaled > SAT_MAX) begin
         out_audio = SAT_MAX[AUDIO_WIDTH-1:0];
      end else if (scaled < SAT_MIN) begin
         out_audio = SAT_MIN[AUDIO_WIDTH-1:0];
      end else begin
         out_audio = scaled[AUDIO_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vp_ff <= 1'b0;
      end else if (en) begin
         va_ff <= va_in;
         vp_ff <= vp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff  <= ang_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = vp_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fmqd_checker.sv -----
// ----------------------------------------------------------------------------
// fmqd_checker
// Port-level checks of the discriminator's output buffering, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fmqd_checker
   import fmqd_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [AUDIO_WIDTH-1:0] rsp_tdata
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   a_backpressure_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with no pending result");

   a_stall_origin : assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req stall without an rsp stall");

   a_no_accept_stalled : assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready |=> !req_tready)
      else $error("stall released without an rsp transaction");

endmodule

bind fm_quadrature_discriminator fmqd_checker u_fmqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
